// ===== hdl/ile_pkg.sv =====
package ile_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int POS_W          = 4;
  localparam int ELEM_W         = 32;
  localparam int COUNT_W        = 5;
  localparam int CMD_W          = 4;
  localparam int STATUS_W       = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 4'd0,
    CMD_INS_TAIL = 4'd1,
    CMD_INS_AT   = 4'd2,
    CMD_RM_HEAD  = 4'd3,
    CMD_RM_TAIL  = 4'd4,
    CMD_RM_AT    = 4'd5,
    CMD_REPLACE  = 4'd6,
    CMD_GET      = 4'd7,
    CMD_EXISTS   = 4'd8,
    CMD_EQUAL_AT = 4'd9,
    CMD_SWAP     = 4'd10,
    CMD_CLEAR    = 4'd11
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_OPEN  = 3'd1,
    CELL_CLOSE = 3'd2,
    CELL_WRITE = 3'd3,
    CELL_SWAP  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     hit_a;
    logic     hit_b;
    logic     past_a;
  } cell_ctrl_t;

endpackage

// ===== hdl/indexed_list_engine.sv =====
// Ordered list of up to CAPACITY words held in a row of cells, one word per
// cell; each cell loads from its left or right neighbor to open or close a
// gap, so inserts, removals, swaps and searches act on all cells at once. One
// item is accepted per cycle and its result appears in the output register
// on the next cycle; the input stays ready while that register is empty or
// being taken. Elements are kept as their low DATA_WIDTH bits, the list
// count starts at zero after reset, and a rejected command changes nothing.
module indexed_list_engine import ile_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // element[31:0], position[35:32], other_position[39:36]
  input  logic [3:0]  s_axis_tuser,  // command[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // status[1:0], found[2], item[34:3], count[39:35]
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FILL_W = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (FILL_W > POS_W) ? FILL_W : POS_W;

  logic                  accept;
  logic [FILL_W-1:0]     fill;
  logic [FILL_W-1:0]     fill_next;
  logic [DATA_WIDTH-1:0] word;
  logic [CMP_W-1:0]      fill_ext;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      pos2_ext;
  logic [CMP_W-1:0]      target_a;
  logic [CMP_W-1:0]      target_b;
  logic                  pos_ok;
  logic                  pos2_ok;
  logic                  full;
  logic                  empty;
  cell_op_t              cell_op;
  logic [DATA_WIDTH-1:0] val_a;
  logic [DATA_WIDTH-1:0] val_b;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  cell_ctrl_t            cell_ctrl [CAPACITY];
  logic [CAPACITY-1:0]   match_vec;
  logic [CAPACITY-1:0]   valid_vec;
  status_t               status_next;
  logic                  found_next;
  logic [ELEM_W-1:0]     item_next;
  status_t               status;
  logic                  found;
  logic [ELEM_W-1:0]     item;
  logic [COUNT_W-1:0]    count;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign word     = DATA_WIDTH'($unsigned(s_axis_tdata[31:0]));
  assign fill_ext = CMP_W'(fill);
  assign pos_ext  = CMP_W'(s_axis_tdata[35:32]);
  assign pos2_ext = CMP_W'(s_axis_tdata[39:36]);
  assign pos_ok   = pos_ext < fill_ext;
  assign pos2_ok  = pos2_ext < fill_ext;
  assign full     = (fill == FILL_W'(CAPACITY));
  assign empty    = (fill == '0);

  assign val_a = cell_data[pos_ext[IDX_W-1:0]];
  assign val_b = cell_data[pos2_ext[IDX_W-1:0]];

  always_comb begin
    cell_op     = CELL_HOLD;
    target_a    = pos_ext;
    target_b    = pos2_ext;
    fill_next   = fill;
    status_next = ST_OK;
    found_next  = 1'b0;
    item_next   = '0;
    case (cmd_t'(s_axis_tuser))
      CMD_INS_HEAD: begin
        target_a = '0;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cell_op   = CELL_OPEN;
          fill_next = fill + 1'b1;
        end
      end
      CMD_INS_TAIL: begin
        target_a = fill_ext;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cell_op   = CELL_WRITE;
          fill_next = fill + 1'b1;
        end
      end
      CMD_INS_AT: begin
        if (!pos_ok) begin
          status_next = ST_RANGE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          cell_op   = CELL_OPEN;
          fill_next = fill + 1'b1;
        end
      end
      CMD_RM_HEAD: begin
        target_a = '0;
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          cell_op   = CELL_CLOSE;
          fill_next = fill - 1'b1;
        end
      end
      CMD_RM_TAIL: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          fill_next = fill - 1'b1;
        end
      end
      CMD_RM_AT: begin
        if (!pos_ok) begin
          status_next = ST_RANGE;
        end else begin
          cell_op   = CELL_CLOSE;
          fill_next = fill - 1'b1;
        end
      end
      CMD_REPLACE: begin
        if (!pos_ok) begin
          status_next = ST_RANGE;
        end else begin
          cell_op = CELL_WRITE;
        end
      end
      CMD_GET: begin
        if (!pos_ok) begin
          status_next = ST_RANGE;
        end else begin
          item_next = ELEM_W'(val_a);
        end
      end
      CMD_EXISTS: begin
        found_next = |(match_vec & valid_vec);
      end
      CMD_EQUAL_AT: begin
        if (!pos_ok) begin
          status_next = ST_RANGE;
        end else begin
          found_next = (val_a == word);
        end
      end
      CMD_SWAP: begin
        if (!pos_ok || !pos2_ok) begin
          status_next = ST_RANGE;
        end else begin
          cell_op = CELL_SWAP;
        end
      end
      CMD_CLEAR: begin
        fill_next = '0;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    assign cell_ctrl[i] = '{
      op:     accept ? cell_op : CELL_HOLD,
      hit_a:  (CMP_W'(i) == target_a),
      hit_b:  (CMP_W'(i) == target_b),
      past_a: (CMP_W'(i) > target_a)
    };
    assign valid_vec[i] = (CMP_W'(i) < fill_ext);

    if (i == 0) begin : g_first
      assign left_data = word;
    end else begin : g_inner
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_body
      assign right_data = cell_data[i+1];
    end

    ile_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .word      (word),
      .left_data (left_data),
      .right_data(right_data),
      .val_a     (val_a),
      .val_b     (val_b),
      .data      (cell_data[i]),
      .match     (match_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        fill          <= fill_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      found  <= found_next;
      item   <= item_next;
      count  <= COUNT_W'(fill_next);
    end
  end

  assign m_axis_tdata = {count, item, found, status};

endmodule

// ===== hdl/ile_cell.sv =====
module ile_cell import ile_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] val_a,
  input  logic [DATA_WIDTH-1:0] val_b,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  match
);

  logic [DATA_WIDTH-1:0] data_next;

  always_comb begin
    data_next = data;
    case (ctrl.op)
      CELL_OPEN: begin
        if (ctrl.past_a) begin
          data_next = left_data;
        end else if (ctrl.hit_a) begin
          data_next = word;
        end
      end
      CELL_CLOSE: begin
        if (ctrl.hit_a || ctrl.past_a) begin
          data_next = right_data;
        end
      end
      CELL_WRITE: begin
        if (ctrl.hit_a) begin
          data_next = word;
        end
      end
      CELL_SWAP: begin
        if (ctrl.hit_a) begin
          data_next = val_b;
        end else if (ctrl.hit_b) begin
          data_next = val_a;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign match = (data == word);

endmodule
